### rtl/lppc_pkg.sv
// Package for the lossless pixel predictor codec.
// Holds the shared widths, register indexes, predictor codes and the per-item flag struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lppc_pkg;

	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int SAMPLE_W   = 9;
	localparam int PIX_W      = 8;
	localparam int MODE_W     = 4;
	localparam int FW_W       = 13;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_PREDICTOR_MODE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DECODE_SELECT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd2;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 13'd4096;

	// Predictor codes.
	localparam logic [MODE_W-1:0] MODE_ZERO   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_A      = 4'd1;
	localparam logic [MODE_W-1:0] MODE_B      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_C      = 4'd3;
	localparam logic [MODE_W-1:0] MODE_ABC    = 4'd4;
	localparam logic [MODE_W-1:0] MODE_A_HBC  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_B_HAC  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_AVG    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_MEDIAN = 4'd8;

	// Neighbor availability worked out by the front end for one item.
	typedef struct packed {
		logic has_left;
		logic has_up;
	} item_flags_t;

endpackage

`default_nettype wire

### rtl/lossless_pixel_predictor_codec.sv
// Top level of the lossless pixel predictor codec: configuration registers and wiring
// of front end, item queue and back end. Depends on lppc_pkg, lppc_front, lppc_queue, lppc_back.
// An accepted item passes a queue entry, the compute stage and the output register in order.
// Throughput: one item per cycle while the output is not stalled, set by the loop from the
// left neighbor through the predictor and, when decoding, the residual adder to left_q.
// The line buffer has one read and one write port; a same-column hand-over is bypassed.
// Reset clears control state, neighbors and registers; the line buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lossless_pixel_predictor_codec
	import lppc_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration write port.
	input  wire logic                         write_enable,
	input  wire logic [REG_IDX_W-1:0]         reg_index,
	input  wire logic [CFG_DATA_W-1:0]        write_data,
	// Input items.
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [SAMPLE_W-1:0]   sample_value,
	input  wire logic                         frame_start,
	// Result items.
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [SAMPLE_W-1:0]        result_value,
	output logic [PIX_W-1:0]                  prediction
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = SAMPLE_W + CW + $bits(item_flags_t);

	logic [MODE_W-1:0]   mode_q;
	logic                decode_q;
	logic [FW_W-1:0]     width_q;

	// Front end to queue.
	logic                queue_full;
	logic                push;
	logic [SAMPLE_W-1:0] push_sample;
	logic [CW-1:0]       push_col;
	item_flags_t         push_flags;

	// Queue to back end.
	logic                pop;
	logic                pop_valid;
	logic [QW-1:0]       pop_data;
	logic [SAMPLE_W-1:0] pop_sample;
	logic [CW-1:0]       pop_col;
	item_flags_t         pop_flags;

	logic [SAMPLE_W-1:0] out_result;

	// Configuration registers. Writes to an index beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ZERO;
			decode_q <= 1'b0;
			width_q  <= FRAME_WIDTH_RST;
		end else if (write_enable) begin
			case (reg_index)
				REG_PREDICTOR_MODE: mode_q <= write_data[MODE_W-1:0];
				REG_DECODE_SELECT: decode_q <= write_data[0];
				REG_FRAME_WIDTH: width_q <= write_data[FW_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end only tracks the column and the first row, so it never waits on pixel data.
	lppc_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.frame_start (frame_start),
		.frame_width (width_q),
		.queue_full  (queue_full),
		.push        (push),
		.push_sample (push_sample),
		.push_col    (push_col),
		.push_flags  (push_flags)
	);

	// The queue lets the input keep flowing while the output side is briefly stalled.
	lppc_queue #(
		.DATA_W(QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_sample, push_col, push_flags}),
		.full     (queue_full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_data (pop_data)
	);

	assign {pop_sample, pop_col, pop_flags} = pop_data;

	// The back end reads the upper neighbor, predicts, and writes the row buffer.
	lppc_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.predictor_mode(mode_q),
		.decode_select (decode_q),
		.pop_valid     (pop_valid),
		.pop_sample    (pop_sample),
		.pop_col       (pop_col),
		.pop_flags     (pop_flags),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_result    (out_result),
		.out_pred      (prediction)
	);

	assign result_value = $signed(out_result);

endmodule

`default_nettype wire

### rtl/lppc_front.sv
// Front end of the pixel predictor codec: accepts items and tracks raster position.
// Tags each item with its column and neighbor flags. Depends on lppc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lppc_front
	import lppc_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic                       frame_start,
	input  wire logic [FW_W-1:0]            frame_width,
	input  wire logic                       queue_full,
	output logic                            push,
	output logic [SAMPLE_W-1:0]             push_sample,
	output logic [CW-1:0]                   push_col,
	output item_flags_t                     push_flags
);

	localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

	logic [CW-1:0] col_q;
	logic          first_row_q;
	logic [CW-1:0] col_cur;
	logic          first_cur;
	logic [WW-1:0] width_eff;
	logic [WW-1:0] col_inc;

	always_comb begin
		// A width of zero or beyond the line buffer means a full-length row.
		if (frame_width == '0 || WW'(frame_width) > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(frame_width);
		end
		col_cur   = frame_start ? '0 : col_q;
		first_cur = frame_start | first_row_q;
		col_inc   = WW'(col_cur) + WW'(1);
	end

	assign in_ready                = !queue_full;
	assign push                    = in_valid && in_ready;
	assign push_sample             = sample_value;
	assign push_col                = col_cur;
	assign push_flags.has_left     = (col_cur != '0);
	assign push_flags.has_up       = !first_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (push) begin
			if (col_inc >= width_eff) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q       <= col_inc[CW-1:0];
				first_row_q <= first_cur;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lppc_queue.sv
// Short FIFO between the front end and the back end of the pixel predictor codec.
// Generic width and depth. Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none

module lppc_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2,
	localparam int PW = $clog2(DEPTH),
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   pop_valid,
	output logic [DATA_W-1:0]      pop_data
);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue holds more items than its depth");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_no_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");

endmodule

`default_nettype wire

### rtl/lppc_back.sv
// Back end of the pixel predictor codec: line buffer, predictor and residual arithmetic.
// Takes tagged items from the queue and drives the output register. Depends on lppc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lppc_back
	import lppc_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [MODE_W-1:0]   predictor_mode,
	input  wire logic                decode_select,
	input  wire logic                pop_valid,
	input  wire logic [SAMPLE_W-1:0] pop_sample,
	input  wire logic [CW-1:0]       pop_col,
	input  wire item_flags_t         pop_flags,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [SAMPLE_W-1:0]      out_result,
	output logic [PIX_W-1:0]         out_pred
);

	function automatic logic [PIX_W-1:0] predict(
		input logic [MODE_W-1:0] mode,
		input item_flags_t       fl,
		input logic [PIX_W-1:0]  a,
		input logic [PIX_W-1:0]  b,
		input logic [PIX_W-1:0]  c
	);
		logic signed [10:0] sa;
		logic signed [10:0] sb;
		logic signed [10:0] sc;
		logic signed [10:0] d;
		logic signed [10:0] p;
		logic               both;
		sa   = {3'b000, a};
		sb   = {3'b000, b};
		sc   = {3'b000, c};
		both = fl.has_left & fl.has_up;
		p    = '0;
		d    = '0;
		case (mode)
			MODE_ZERO: p = '0;
			MODE_A: if (fl.has_left) p = sa;
			MODE_B: if (fl.has_up) p = sb;
			MODE_C: if (both) p = sc;
			MODE_ABC: if (both) p = sa + sb - sc;
			MODE_A_HBC: if (both) begin
				// Halving of a signed difference rounds toward zero.
				d = sb - sc;
				p = sa + ((d + $signed({10'b0, d[10]})) >>> 1);
			end
			MODE_B_HAC: if (both) begin
				d = sa - sc;
				p = sb + ((d + $signed({10'b0, d[10]})) >>> 1);
			end
			MODE_AVG: if (both) p = (sa + sb) >>> 1;
			MODE_MEDIAN: if (both) begin
				if (c >= ((b < a) ? a : b)) begin
					p = (b < a) ? sb : sa;
				end else if (c <= ((b < a) ? b : a)) begin
					p = (b < a) ? sa : sb;
				end else begin
					p = sa + sb - sc;
				end
			end
			default: p = '0;
		endcase
		if (p < 0) begin
			return '0;
		end else if (p > 11'sd255) begin
			return 8'hFF;
		end
		return p[PIX_W-1:0];
	endfunction

	logic [PIX_W-1:0]    row_mem [MAX_WIDTH];
	logic [PIX_W-1:0]    rd_data_s1;

	logic                s1_valid_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CW-1:0]       col_s1;
	item_flags_t         flags_s1;
	logic                byp_s1;
	logic [PIX_W-1:0]    byp_pix_s1;

	logic [PIX_W-1:0]    left_q;
	logic [PIX_W-1:0]    upleft_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] result_q;
	logic [PIX_W-1:0]    pred_q;

	logic                s1_leave;
	logic [PIX_W-1:0]    upper;
	logic [PIX_W-1:0]    pred;
	logic [PIX_W-1:0]    pixel;
	logic [SAMPLE_W-1:0] result;

	assign s1_leave = s1_valid_q && (!out_valid_q || out_ready);
	assign pop      = pop_valid && (!s1_valid_q || s1_leave);

	always_comb begin
		// The pixel just written is newer than what the memory returned.
		upper = byp_s1 ? byp_pix_s1 : rd_data_s1;
		pred  = predict(predictor_mode, flags_s1, left_q, upper, upleft_q);
		if (decode_select) begin
			pixel  = pred + sample_s1[PIX_W-1:0];
			result = {1'b0, pixel};
		end else begin
			pixel  = sample_s1[PIX_W-1:0];
			result = {1'b0, pixel} - {1'b0, pred};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_data_s1 <= row_mem[pop_col];
			sample_s1  <= pop_sample;
			col_s1     <= pop_col;
			flags_s1   <= pop_flags;
			byp_s1     <= s1_leave && (col_s1 == pop_col);
			byp_pix_s1 <= pixel;
		end
		if (s1_leave) begin
			row_mem[col_s1] <= pixel;
			result_q        <= result;
			pred_q          <= pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			upleft_q    <= '0;
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_leave) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_leave) begin
				out_valid_q <= 1'b1;
				left_q      <= pixel;
				upleft_q    <= upper;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;
	assign out_pred   = pred_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s1_leave |-> !(out_valid_q && !out_ready))
		else $error("compute stage advanced into a stalled output register");

	a_bypass_taken: assert property (@(posedge clk) disable iff (!arst_n)
		pop && s1_leave && (col_s1 == pop_col) |=> byp_s1)
		else $error("same-column hand-over missed the bypass");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_leave |=> out_valid_q)
		else $error("item left the compute stage without a result");

endmodule

`default_nettype wire
